@@ rtl/core/nssa_pkg.sv @@
// ----------------------------------------------------------------------------
// nssa_pkg
// Shared types and constants of the nearest station slot assigner.
// ----------------------------------------------------------------------------
package nssa_pkg;

    // Operation codes of an input item
    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_ATTACH = 2'd1,
        FUNC_MOVE   = 2'd2,
        FUNC_LEAVE  = 2'd3
    } func_e_t;

    // Status codes of a result item
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_e_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_REMOVE,
        S_REPORT,
        S_SCAN,
        S_FINISH
    } state_t;

    // Squared distance cut-off (distance below ten million)
    localparam logic [63:0] DIST_LIMIT_SQ = 64'd100000000000000;

    typedef struct packed {
        logic [1:0]         func;
        logic [15:0]        terminal_id;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic               was_connected;
        logic [3:0]         current_station;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] station_index;
        logic [2:0] slot_index;
        logic [3:0] slots_used;
    } res_item_t;

    // Per-cell strobes from the sequencer
    typedef struct packed {
        logic add_en;
        logic rm_en;
        logic app_en;
    } cell_cmd_t;

endpackage

@@ rtl/core/nssa_cell.sv @@
// ----------------------------------------------------------------------------
// nssa_cell
// One station: position, slot list and fill, squared distance to the
// terminal, and one stage of the nearest-station chain.
// ----------------------------------------------------------------------------
module nssa_cell #(
    parameter int SLOTS      = 8,
    parameter int COORD_BITS = 16,
    parameter int ID_BITS    = 16,
    parameter int SW         = 4,
    parameter int FW         = 4,
    parameter int IW         = 3,
    parameter int DW         = 36,
    parameter int IDX        = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nssa_pkg::cell_cmd_t          cmd,
    input  logic                         active,
    input  logic [ID_BITS-1:0]           id,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic signed [COORD_BITS-1:0] pz,
    input  logic                         best_found_in,
    input  logic [SW-1:0]                best_idx_in,
    input  logic [DW-1:0]                best_dist_in,
    output logic                         best_found_out,
    output logic [SW-1:0]                best_idx_out,
    output logic [DW-1:0]                best_dist_out,
    output logic [FW-1:0]                fill,
    output logic                         hit
);

    localparam int QW = 2 * COORD_BITS + 2;

    logic signed [COORD_BITS-1:0] sx_reg, sy_reg, sz_reg;
    logic [FW-1:0]                fill_reg, fill_next;
    logic [ID_BITS-1:0]           ids_reg [SLOTS];
    logic [ID_BITS-1:0]           ids_next [SLOTS];
    logic [QW-1:0]                qx_reg, qy_reg, qz_reg;
    logic [DW-1:0]                dist_reg;
    logic                         bf_reg;
    logic [SW-1:0]                bi_reg;
    logic [DW-1:0]                bd_reg;
    logic signed [COORD_BITS:0]   dx, dy, dz;
    logic [SLOTS-1:0]             match;
    logic                         own_ok;
    logic                         take;

    // Coordinate differences
    assign dx = $signed({px[COORD_BITS-1], px}) - $signed({sx_reg[COORD_BITS-1], sx_reg});
    assign dy = $signed({py[COORD_BITS-1], py}) - $signed({sy_reg[COORD_BITS-1], sy_reg});
    assign dz = $signed({pz[COORD_BITS-1], pz}) - $signed({sz_reg[COORD_BITS-1], sz_reg});

    // Squares at full width, then their sum
    always_ff @(posedge clk)
    begin
        qx_reg   <= $unsigned(QW'(dx) * QW'(dx));
        qy_reg   <= $unsigned(QW'(dy) * QW'(dy));
        qz_reg   <= $unsigned(QW'(dz) * QW'(dz));
        dist_reg <= DW'(qx_reg) + DW'(qy_reg) + DW'(qz_reg);
    end

    // Find id among occupied slots
    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            match[j] = (32'(j) < 32'(fill_reg)) && (ids_reg[j] == id);
        end
    end

    assign hit = active && (|match);

    // Remove first match by shifting later ids down, or append, or clear
    always_comb
    begin
        logic seen;
        seen      = 1'b0;
        fill_next = fill_reg;
        for (int j = 0; j < SLOTS; j++)
        begin
            ids_next[j] = ids_reg[j];
        end
        if (cmd.add_en)
        begin
            fill_next = '0;
        end
        else if (cmd.rm_en && hit)
        begin
            for (int j = 0; j < SLOTS; j++)
            begin
                seen = seen | match[j];
                if (seen && (j + 1 < SLOTS))
                begin
                    ids_next[j] = ids_reg[(j + 1) % SLOTS];
                end
            end
            fill_next = fill_reg - FW'(1);
        end
        else if (cmd.app_en)
        begin
            ids_next[fill_reg[IW-1:0]] = id;
            fill_next = fill_reg + FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // Station position and slot ids
    always_ff @(posedge clk)
    begin
        if (cmd.add_en)
        begin
            sx_reg <= px;
            sy_reg <= py;
            sz_reg <= pz;
        end
        for (int j = 0; j < SLOTS; j++)
        begin
            ids_reg[j] <= ids_next[j];
        end
    end

    // Chain stage: keep the incoming best or take this station
    assign own_ok = active && (32'(fill_reg) < 32'(SLOTS))
                  && (64'(dist_reg) < nssa_pkg::DIST_LIMIT_SQ);
    assign take   = own_ok && (!best_found_in || (dist_reg < best_dist_in));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bf_reg <= 1'b0;
        end
        else
        begin
            bf_reg <= best_found_in || take;
        end
    end

    always_ff @(posedge clk)
    begin
        bi_reg <= take ? SW'(IDX) : best_idx_in;
        bd_reg <= take ? dist_reg : best_dist_in;
    end

    assign best_found_out = bf_reg;
    assign best_idx_out   = bi_reg;
    assign best_dist_out  = bd_reg;
    assign fill           = fill_reg;

endmodule

@@ rtl/core/nearest_station_slot_assigner_core.sv @@
// ----------------------------------------------------------------------------
// nearest_station_slot_assigner_core
// Station table with per-station slot lists; attaches a terminal to the
// nearest station with a free slot through a chain of station cells.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  cmd     | cmd_valid, cmd_stall, cmd_item  | item in
//  res     | res_valid, res_stall, res_item  | result out, one per item
//
//  Add runs S_ADD, S_FINISH; leave S_REMOVE, S_REPORT, S_FINISH; attach S_SCAN,
//  S_FINISH, and a move of a connected terminal S_REMOVE first. In S_SCAN the
//  distances form in the square and sum registers, then the search walks the
//  cell chain one cell a cycle. The next item can be taken once the result rises.
//  Reset clears station count and all slot fills at once; no clearing pass.
//  One item is in work at a time; a waiting result sits in the output register
//  and the next item is taken meanwhile.
module nearest_station_slot_assigner_core #(
    parameter int MAX_STATIONS      = 16,
    parameter int SLOTS_PER_STATION = 8,
    parameter int COORD_BITS        = 16,
    parameter int ID_BITS           = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  nssa_pkg::cmd_item_t   cmd_item,
    output logic                  res_valid,
    input  logic                  res_stall,
    output nssa_pkg::res_item_t   res_item
);

    localparam int SW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
    localparam int CW = $clog2(MAX_STATIONS + 1);
    localparam int FW = $clog2(SLOTS_PER_STATION + 1);
    localparam int IW = (SLOTS_PER_STATION > 1) ? $clog2(SLOTS_PER_STATION) : 1;
    localparam int DW = 2 * COORD_BITS + 4;
    localparam int TW = $clog2(MAX_STATIONS + 3);

    nssa_pkg::state_t     state_reg, state_next;
    nssa_pkg::cmd_item_t  item_reg;
    nssa_pkg::res_item_t  res_reg, res_next;
    nssa_pkg::res_item_t  out_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [TW-1:0]        tick_reg, tick_next;
    logic                 hit_reg, hit_next;

    logic [ID_BITS-1:0]           id_w;
    logic signed [COORD_BITS-1:0] px_w, py_w, pz_w;
    logic                         bf_w [MAX_STATIONS+1];
    logic [SW-1:0]                bi_w [MAX_STATIONS+1];
    logic [DW-1:0]                bd_w [MAX_STATIONS+1];
    logic [FW-1:0]                fill_w [MAX_STATIONS];
    logic [MAX_STATIONS-1:0]      hit_w;
    logic [SW-1:0]                cur_sw;
    logic                         cur_ok;
    logic                         accept;
    logic                         out_free;
    logic [SW-1:0]                pick_w;

    // Field views at the configured widths
    assign id_w = ID_BITS'(32'(item_reg.terminal_id));
    assign px_w = COORD_BITS'(32'($unsigned(item_reg.pos_x)));
    assign py_w = COORD_BITS'(32'($unsigned(item_reg.pos_y)));
    assign pz_w = COORD_BITS'(32'($unsigned(item_reg.pos_z)));

    assign cur_sw = SW'(32'(item_reg.current_station));
    assign cur_ok = 32'(item_reg.current_station) < 32'(count_reg);
    assign pick_w = bi_w[MAX_STATIONS];

    assign bf_w[0] = 1'b0;
    assign bi_w[0] = '0;
    assign bd_w[0] = '0;

    // Row of station cells
    for (genvar i = 0; i < MAX_STATIONS; i++)
    begin : g_cell
        nssa_pkg::cell_cmd_t cc;
        always_comb
        begin
            cc.add_en = (state_reg == nssa_pkg::S_ADD)
                      && (32'(count_reg) < 32'(MAX_STATIONS))
                      && (32'(count_reg) == 32'(i));
            cc.rm_en  = (state_reg == nssa_pkg::S_REMOVE) && cur_ok
                      && (32'(cur_sw) == 32'(i));
            cc.app_en = (state_reg == nssa_pkg::S_SCAN)
                      && (32'(tick_reg) == 32'(MAX_STATIONS + 2))
                      && bf_w[MAX_STATIONS] && (32'(pick_w) == 32'(i));
        end

        nssa_cell #(
            .SLOTS      (SLOTS_PER_STATION),
            .COORD_BITS (COORD_BITS),
            .ID_BITS    (ID_BITS),
            .SW         (SW),
            .FW         (FW),
            .IW         (IW),
            .DW         (DW),
            .IDX        (i)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .cmd            (cc),
            .active         (32'(count_reg) > 32'(i)),
            .id             (id_w),
            .px             (px_w),
            .py             (py_w),
            .pz             (pz_w),
            .best_found_in  (bf_w[i]),
            .best_idx_in    (bi_w[i]),
            .best_dist_in   (bd_w[i]),
            .best_found_out (bf_w[i+1]),
            .best_idx_out   (bi_w[i+1]),
            .best_dist_out  (bd_w[i+1]),
            .fill           (fill_w[i]),
            .hit            (hit_w[i])
        );
    end

    assign accept   = cmd_valid && !cmd_stall;
    assign out_free = !out_valid_reg || !res_stall;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        tick_next      = tick_reg;
        hit_next       = hit_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && res_stall;
        case (state_reg)
            nssa_pkg::S_IDLE:
            begin
                tick_next = '0;
                if (accept)
                begin
                    if (cmd_item.func == nssa_pkg::FUNC_ADD)
                    begin
                        state_next = nssa_pkg::S_ADD;
                    end
                    else if (cmd_item.func == nssa_pkg::FUNC_LEAVE
                             || (cmd_item.func == nssa_pkg::FUNC_MOVE
                                 && cmd_item.was_connected))
                    begin
                        state_next = nssa_pkg::S_REMOVE;
                    end
                    else
                    begin
                        state_next = nssa_pkg::S_SCAN;
                    end
                end
            end
            nssa_pkg::S_ADD:
            begin
                res_next = '0;
                if (32'(count_reg) >= 32'(MAX_STATIONS))
                begin
                    res_next.status = nssa_pkg::ST_FULL;
                end
                else
                begin
                    res_next.station_index = 4'(count_reg);
                    count_next = count_reg + CW'(1);
                end
                state_next = nssa_pkg::S_FINISH;
            end
            nssa_pkg::S_REMOVE:
            begin
                hit_next   = cur_ok && hit_w[cur_sw];
                state_next = (item_reg.func == nssa_pkg::FUNC_LEAVE)
                           ? nssa_pkg::S_REPORT : nssa_pkg::S_SCAN;
            end
            nssa_pkg::S_REPORT:
            begin
                res_next = '0;
                res_next.status = hit_reg ? nssa_pkg::ST_OK : nssa_pkg::ST_NOT_FOUND;
                res_next.station_index = item_reg.current_station;
                res_next.slots_used = cur_ok ? 4'(fill_w[cur_sw]) : 4'd0;
                state_next = nssa_pkg::S_FINISH;
            end
            nssa_pkg::S_SCAN:
            begin
                tick_next = tick_reg + TW'(1);
                if (32'(tick_reg) == 32'(MAX_STATIONS + 2))
                begin
                    res_next = '0;
                    if (bf_w[MAX_STATIONS])
                    begin
                        res_next.status = (item_reg.func == nssa_pkg::FUNC_MOVE
                                           && item_reg.was_connected && !hit_reg)
                                        ? nssa_pkg::ST_NOT_FOUND : nssa_pkg::ST_OK;
                        res_next.station_index = 4'(pick_w);
                        res_next.slot_index    = 3'(fill_w[pick_w]);
                        res_next.slots_used    = 4'(fill_w[pick_w] + FW'(1));
                    end
                    else
                    begin
                        res_next.status = nssa_pkg::ST_NO_FREE;
                    end
                    state_next = nssa_pkg::S_FINISH;
                end
            end
            nssa_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = nssa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nssa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nssa_pkg::S_IDLE;
            count_reg     <= '0;
            tick_reg      <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            tick_reg      <= tick_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold item, result and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd_item;
        end
        res_reg <= res_next;
        if (state_reg == nssa_pkg::S_FINISH && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    assign cmd_stall = (state_reg != nssa_pkg::S_IDLE);
    assign res_valid = out_valid_reg;
    assign res_item  = out_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(MAX_STATIONS))
        else $error("station count beyond table size");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> cmd_stall)
        else $error("item taken while another is in work");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == nssa_pkg::S_FINISH))
        else $error("result raised outside finish");

endmodule
